@@ rtl/core/npcs_pkg.sv @@
package npcs_pkg;

    // Default palette depth; the top level parameter takes it from here.
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Squared distance reported when no entry is searched.
    localparam logic [17:0] EMPTY_DISTANCE = 18'(256 * 256 * 3);

    // Command codes carried in the request beat.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic       command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] entry_index;
        logic [7:0] range_start;
        logic [7:0] range_end;
    } request_t;

    typedef struct packed {
        logic [7:0]  best_index;
        logic [17:0] best_distance;
    } result_t;

    // Travels alongside each palette read through the distance pipeline.
    typedef struct packed {
        logic       valid;
        logic [7:0] index;
    } tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

@@ rtl/core/nearest_palette_color_search_top.sv @@
// Channel   Direction  Handshake                      Beat
// request   in         start high while busy is low   request_t: command, color, indices
// result    out        result_valid, one cycle        result_t: best_index, best_distance
//
// A write is stored at the accepting edge and busy stays low. A query scans
// its range through the single palette read port, one entry per cycle, and
// each read then passes the read register and the distance pipeline; the
// result strobe follows once they have drained, and busy stays high until
// the result has been shown. A query that searches no entry strobes without
// a scan. After reset a clearing pass zeroes the palette with busy high. The
// receiver cannot stall: each result is shown for one cycle.
module nearest_palette_color_search_top #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  npcs_pkg::request_t request,
    output logic               busy,
    output logic               result_valid,
    output npcs_pkg::result_t  result
);

    // Address width of the palette memory and width of the scan index. The
    // index is one bit wider than any address or 8-bit field so that the
    // position one past the last entry can still be represented.
    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int IW = ((AW > 8) ? AW : 8) + 1;
    localparam logic [IW-1:0] TOP_INDEX  = IW'(PALETTE_ENTRIES - 1);
    localparam logic [IW-1:0] ENTRY_COUNT = IW'(PALETTE_ENTRIES);
    localparam logic [AW-1:0] CLEAR_LAST = AW'(PALETTE_ENTRIES - 1);

    npcs_pkg::state_t state_reg, state_next;

    // Query context held for the whole scan, and the clearing pass counter.
    npcs_pkg::rgb_t  color_reg, color_next;
    logic [IW-1:0]   scan_reg, scan_next;
    logic [IW-1:0]   lim_reg, lim_next;
    logic [AW-1:0]   clr_reg, clr_next;

    // Running minimum; strict compare keeps the lowest index on ties since
    // entries arrive in increasing index order.
    logic [7:0]      best_idx_reg, best_idx_next;
    logic [17:0]     best_dist_reg, best_dist_next;

    npcs_pkg::tag_t  rd_tag_reg, rd_tag_next;
    npcs_pkg::tag_t  sum_tag;
    logic [17:0]     sum_dist;
    logic            dist_active;

    logic            accept;
    logic            issue;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    npcs_pkg::rgb_t  wr_data;
    npcs_pkg::rgb_t  rd_data;
    npcs_pkg::rgb_t  req_color;
    logic [IW-1:0]   req_last;

    assign accept    = start && !busy;
    assign issue     = (state_reg == npcs_pkg::ST_SCAN) && (scan_reg <= lim_reg);
    assign req_color = '{red: request.red, green: request.green, blue: request.blue};
    assign req_last  = IW'(request.range_end);

    // The palette write port serves both the clearing pass and write beats.
    // Write beats land only while idle and clearing writes only before it, so neither overlaps a scan's reads.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        if (state_reg == npcs_pkg::ST_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (accept && (request.command == npcs_pkg::CMD_WRITE)
                 && (IW'(request.entry_index) < ENTRY_COUNT))
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(request.entry_index);
            wr_data = req_color;
        end
    end

    npcs_ram #(
        .DEPTH (PALETTE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    npcs_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .color    (color_reg),
        .entry    (rd_data),
        .tag_in   (rd_tag_reg),
        .tag_out  (sum_tag),
        .distance (sum_dist),
        .active   (dist_active)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            npcs_pkg::ST_CLEAR:
            begin
                if (clr_reg == CLEAR_LAST)
                begin
                    state_next = npcs_pkg::ST_IDLE;
                end
            end
            npcs_pkg::ST_IDLE:
            begin
                if (accept && (request.command == npcs_pkg::CMD_QUERY))
                begin
                    state_next = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN:
            begin
                if (!issue)
                begin
                    state_next = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN:
            begin
                if (!rd_tag_reg.valid && !dist_active)
                begin
                    state_next = npcs_pkg::ST_DONE;
                end
            end
            npcs_pkg::ST_DONE:
            begin
                state_next = npcs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        color_next     = color_reg;
        scan_next      = scan_reg;
        lim_next       = lim_reg;
        clr_next       = clr_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        rd_tag_next.valid = issue;
        rd_tag_next.index = scan_reg[7:0];

        if (state_reg == npcs_pkg::ST_CLEAR)
        begin
            clr_next = clr_reg + 1'b1;
        end

        if (accept && (request.command == npcs_pkg::CMD_QUERY))
        begin
            // Clip the range end to the last entry; a start beyond it then
            // issues no read and the answer falls back to the start index.
            color_next     = req_color;
            scan_next      = IW'(request.range_start);
            lim_next       = (req_last > TOP_INDEX) ? TOP_INDEX : req_last;
            best_idx_next  = request.range_start;
            best_dist_next = npcs_pkg::EMPTY_DISTANCE;
        end
        else if (issue)
        begin
            scan_next = scan_reg + 1'b1;
        end

        if (sum_tag.valid && (sum_dist < best_dist_reg))
        begin
            best_idx_next  = sum_tag.index;
            best_dist_next = sum_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= npcs_pkg::ST_CLEAR;
            clr_reg    <= '0;
            rd_tag_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            rd_tag_reg <= rd_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        scan_reg      <= scan_next;
        lim_reg       <= lim_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    // Outputs.
    always_comb
    begin
        busy                 = (state_reg != npcs_pkg::ST_IDLE);
        result_valid         = (state_reg == npcs_pkg::ST_DONE);
        result.best_index    = best_idx_reg;
        result.best_distance = best_dist_reg;
    end

    // A result is only ever shown right after the pipeline has drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == npcs_pkg::ST_DRAIN))
        else $error("result shown before the distance pipeline drained");

    // The palette is never written while a query is reading it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == npcs_pkg::ST_SCAN || state_reg == npcs_pkg::ST_DRAIN) |-> !wr_en)
        else $error("palette written during a query");

    // No stale distance may still be in flight when the result is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!rd_tag_reg.valid && !dist_active && !sum_tag.valid))
        else $error("distance pipeline busy at result");

    // A reported distance never exceeds the empty-range value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.best_distance <= npcs_pkg::EMPTY_DISTANCE))
        else $error("best distance out of range");

endmodule

@@ rtl/core/npcs_ram.sv @@
module npcs_ram #(
    parameter int DEPTH = npcs_pkg::PALETTE_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  npcs_pkg::rgb_t wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output npcs_pkg::rgb_t rd_data
);

    npcs_pkg::rgb_t mem [DEPTH];
    npcs_pkg::rgb_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/npcs_dist.sv @@
module npcs_dist (
    input  logic           clk,
    input  logic           rst_n,
    input  npcs_pkg::rgb_t color,
    input  npcs_pkg::rgb_t entry,
    input  npcs_pkg::tag_t tag_in,
    output npcs_pkg::tag_t tag_out,
    output logic [17:0]    distance,
    output logic           active
);

    // Three stages: absolute differences, squares, sum.
    npcs_pkg::rgb_t diff_reg, diff_next;
    npcs_pkg::tag_t tag1_reg, tag2_reg, tag3_reg;
    logic [15:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [15:0]    sq_r_next, sq_g_next, sq_b_next;
    logic [17:0]    sum_reg, sum_next;

    always_comb
    begin
        diff_next.red   = (color.red > entry.red) ? color.red - entry.red
                                                  : entry.red - color.red;
        diff_next.green = (color.green > entry.green) ? color.green - entry.green
                                                      : entry.green - color.green;
        diff_next.blue  = (color.blue > entry.blue) ? color.blue - entry.blue
                                                    : entry.blue - color.blue;
        sq_r_next = 16'(diff_reg.red) * 16'(diff_reg.red);
        sq_g_next = 16'(diff_reg.green) * 16'(diff_reg.green);
        sq_b_next = 16'(diff_reg.blue) * 16'(diff_reg.blue);
        sum_next  = 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_r_reg <= sq_r_next;
        sq_g_reg <= sq_g_next;
        sq_b_reg <= sq_b_next;
        sum_reg  <= sum_next;
    end

    assign tag_out  = tag3_reg;
    assign distance = sum_reg;
    assign active   = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid;

endmodule
